// ----- sv/kwtab_pkg.sv -----
// Shared types, operation codes and character helpers for the keyword table.
`timescale 1ns / 1ps

package kwtab_pkg;

    localparam int KEY_CHARS    = 8;
    localparam int PREFIX_CHARS = 5;
    localparam int CHAR_W       = 8;
    localparam int KEY_W        = KEY_CHARS * CHAR_W;
    localparam int PREFIX_W     = PREFIX_CHARS * CHAR_W;
    localparam int POS_W        = 6;
    localparam int COUNT_W      = 7;

    localparam logic [1:0] OP_CLEAR  = 2'd0;
    localparam logic [1:0] OP_APPEND = 2'd1;
    localparam logic [1:0] OP_LOOKUP = 2'd2;

    localparam logic [CHAR_W-1:0] CHAR_SPACE = 8'h20;
    localparam logic [CHAR_W-1:0] CHAR_ZERO  = 8'h30;
    localparam logic [CHAR_W-1:0] CHAR_NINE  = 8'h39;

    typedef struct packed {
        logic [1:0]       operation;
        logic [KEY_W-1:0] keyword;
    } kwtab_in_t;

    typedef struct packed {
        logic               status;
        logic               exact_hit;
        logic               near_hit;
        logic [POS_W-1:0]   position;
        logic [COUNT_W-1:0] entry_count;
    } kwtab_out_t;

    function automatic logic digit_or_space(input logic [CHAR_W-1:0] ch);
        return ((ch >= CHAR_ZERO) && (ch <= CHAR_NINE)) || (ch == CHAR_SPACE);
    endfunction

    function automatic logic numbered_tail(input logic [KEY_W-1:0] word);
        logic ok;
        ok = 1'b1;
        for (int i = 0; i < KEY_CHARS - PREFIX_CHARS; i++) begin
            ok = ok & digit_or_space(word[i*CHAR_W +: CHAR_W]);
        end
        return ok;
    endfunction

endpackage

// ----- sv/keyword_table_exact_near_search.sv -----
// Keyword table with clear, append and sequential exact / numbered-prefix lookup.
`timescale 1ns / 1ps

// A word is taken when start is high and busy is low; its result appears on
// result for one cycle with done high and must be captured then. Clear,
// append and unused codes answer in the cycle after they are taken and leave
// busy low. A lookup reads the keyword memory one entry per cycle through
// its single registered read port, so it answers once every held entry has
// been compared (earlier on an exact hit); busy is high meanwhile.
// Stored words are not cleared by reset or by the clear operation, only
// the entry count is.
module keyword_table_exact_near_search #(
    parameter int TABLE_DEPTH = 64
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  start,
    input  kwtab_pkg::kwtab_in_t  cmd,
    output logic                  busy,
    output logic                  done,
    output kwtab_pkg::kwtab_out_t result
);
    import kwtab_pkg::*;

    localparam int AW = $clog2(TABLE_DEPTH);
    localparam int CW = $clog2(TABLE_DEPTH + 1);

    typedef enum logic {ST_IDLE, ST_SCAN} state_t;

    state_t             state_reg, state_next;
    logic [CW-1:0]      count_reg, count_next;
    logic [CW-1:0]      issue_reg, issue_next;
    logic               rd_vld_reg, rd_vld_next;
    logic [AW-1:0]      rd_idx_reg, rd_idx_next;
    logic               near_found_reg, near_found_next;
    logic [AW-1:0]      near_idx_reg, near_idx_next;
    logic [KEY_W-1:0]   key_reg, key_next;
    logic               done_reg, done_next;
    kwtab_out_t         result_reg, result_next;

    logic [KEY_W-1:0]   mem [TABLE_DEPTH];
    logic [KEY_W-1:0]   rd_data_reg;
    logic               wr_en;
    logic               full;
    logic               issue;
    logic               exact_match;
    logic               near_match;

    assign full        = (count_reg == CW'(TABLE_DEPTH));
    assign issue       = (issue_reg != count_reg);
    assign exact_match = (rd_data_reg == key_reg);
    assign near_match  = (rd_data_reg[KEY_W-1 -: PREFIX_W] == key_reg[KEY_W-1 -: PREFIX_W])
                         && numbered_tail(rd_data_reg);

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[count_reg[AW-1:0]] <= cmd.keyword;
        end
        rd_data_reg <= mem[issue_reg[AW-1:0]];
    end

    always_comb
    begin
        state_next      = state_reg;
        count_next      = count_reg;
        issue_next      = issue_reg;
        rd_vld_next     = rd_vld_reg;
        rd_idx_next     = rd_idx_reg;
        near_found_next = near_found_reg;
        near_idx_next   = near_idx_reg;
        key_next        = key_reg;
        done_next       = 1'b0;
        result_next     = result_reg;
        wr_en           = 1'b0;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    result_next.status      = 1'b0;
                    result_next.exact_hit   = 1'b0;
                    result_next.near_hit    = 1'b0;
                    result_next.position    = '0;
                    result_next.entry_count = COUNT_W'(count_reg);
                    unique case (cmd.operation)
                        OP_CLEAR:
                        begin
                            count_next              = '0;
                            result_next.entry_count = '0;
                            done_next               = 1'b1;
                        end
                        OP_APPEND:
                        begin
                            if (full)
                            begin
                                result_next.status = 1'b1;
                            end
                            else
                            begin
                                wr_en                   = 1'b1;
                                count_next              = count_reg + CW'(1);
                                result_next.entry_count = COUNT_W'(count_reg + CW'(1));
                            end
                            done_next = 1'b1;
                        end
                        OP_LOOKUP:
                        begin
                            state_next      = ST_SCAN;
                            key_next        = cmd.keyword;
                            issue_next      = '0;
                            rd_vld_next     = 1'b0;
                            near_found_next = 1'b0;
                            near_idx_next   = '0;
                        end
                        default:
                        begin
                            done_next = 1'b1;
                        end
                    endcase
                end
            end
            ST_SCAN:
            begin
                rd_vld_next = issue;
                rd_idx_next = issue_reg[AW-1:0];
                if (issue)
                begin
                    issue_next = issue_reg + CW'(1);
                end
                result_next.status      = 1'b0;
                result_next.entry_count = COUNT_W'(count_reg);
                if (rd_vld_reg && exact_match)
                begin
                    state_next            = ST_IDLE;
                    rd_vld_next           = 1'b0;
                    done_next             = 1'b1;
                    result_next.exact_hit = 1'b1;
                    result_next.near_hit  = 1'b0;
                    result_next.position  = POS_W'(rd_idx_reg);
                end
                else
                begin
                    if (rd_vld_reg && near_match)
                    begin
                        near_found_next = 1'b1;
                        near_idx_next   = rd_idx_reg;
                    end
                    if (!rd_vld_reg && !issue)
                    begin
                        state_next            = ST_IDLE;
                        done_next             = 1'b1;
                        result_next.exact_hit = 1'b0;
                        result_next.near_hit  = near_found_reg;
                        result_next.position  = near_found_reg ? POS_W'(near_idx_reg) : '0;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            count_reg      <= '0;
            issue_reg      <= '0;
            rd_vld_reg     <= 1'b0;
            near_found_reg <= 1'b0;
            done_reg       <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            count_reg      <= count_next;
            issue_reg      <= issue_next;
            rd_vld_reg     <= rd_vld_next;
            near_found_reg <= near_found_next;
            done_reg       <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rd_idx_reg   <= rd_idx_next;
        near_idx_reg <= near_idx_next;
        key_reg      <= key_next;
        result_reg   <= result_next;
    end

    assign busy   = (state_reg == ST_SCAN);
    assign done   = done_reg;
    assign result = result_reg;

    a_done_not_busy: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !busy)
        else $error("done while lookup still running");

    a_hits_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !(result.exact_hit && result.near_hit))
        else $error("exact and near hit both reported");

    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CW'(TABLE_DEPTH))
        else $error("entry count beyond table depth");

    a_refuse_only_full: assert property (@(posedge clk) disable iff (!rst_n)
        (done && result.status) |-> full)
        else $error("append refused while table not full");

    a_lookup_goes_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && cmd.operation == OP_LOOKUP) |=> busy)
        else $error("lookup accepted without starting a scan");

endmodule

// ----- verif/keyword_table_exact_near_search_tb.sv -----
// Testbench for the keyword table: queued command driver, result monitor, table predictor.
`timescale 1ns / 1ps

module keyword_table_exact_near_search_tb;
    import kwtab_pkg::*;

    localparam int TABLE_DEPTH = 64;
    localparam int RANDOM_ITEMS = 1000;
    localparam int MAX_GAP = 13;
    localparam int STALL_LIMIT = 2000;
    localparam int DRAIN_CYCLES = TABLE_DEPTH + 16;
    localparam int REPORT_LIMIT = 10;
    localparam logic [1:0] OP_UNUSED = 2'd3;

    logic       clk = 1'b0;
    logic       rst_n = 1'b0;
    logic       start = 1'b0;
    kwtab_in_t  cmd = '0;
    logic       busy;
    logic       done;
    kwtab_out_t result;

    kwtab_in_t  cmd_backlog[$];
    kwtab_out_t expected_results[$];

    // predictor copy of the table
    logic [KEY_W-1:0] held_words[TABLE_DEPTH];
    int               held_count = 0;

    // generator view of the table, tracked while commands are planned
    logic [KEY_W-1:0] planned_words[$];
    logic [PREFIX_W-1:0] stems[4];
    int planned_total = 0;

    int  gap_left = 0;
    int  gap_draw;
    bit  no_idle = 1'b0;
    int  fail_count = 0;
    int  stall_cycles = 0;
    kwtab_out_t want;

    keyword_table_exact_near_search #(
        .TABLE_DEPTH(TABLE_DEPTH)
    ) u_top (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .cmd    (cmd),
        .busy   (busy),
        .done   (done),
        .result (result)
    );

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    function automatic bit tail_char_ok(input logic [CHAR_W-1:0] ch);
        return (ch == 8'h20) || (ch >= 8'h30 && ch <= 8'h39);
    endfunction

    function automatic kwtab_out_t table_outcome(input kwtab_in_t c);
        kwtab_out_t r;
        int near_at;
        logic [KEY_W-1:0] w;
        r = '0;
        near_at = -1;
        case (c.operation)
            OP_CLEAR: held_count = 0;
            OP_APPEND:
            begin
                if (held_count >= TABLE_DEPTH)
                    r.status = 1'b1;
                else
                begin
                    held_words[held_count] = c.keyword;
                    held_count++;
                end
            end
            OP_LOOKUP:
            begin
                for (int i = 0; i < held_count; i++)
                begin
                    w = held_words[i];
                    if (w == c.keyword)
                    begin
                        r.exact_hit = 1'b1;
                        r.position  = POS_W'(i);
                        break;
                    end
                    if (w[KEY_W-1 -: PREFIX_W] == c.keyword[KEY_W-1 -: PREFIX_W]
                        && tail_char_ok(w[23:16]) && tail_char_ok(w[15:8])
                        && tail_char_ok(w[7:0]))
                        near_at = i;
                end
                if (!r.exact_hit && near_at >= 0)
                begin
                    r.near_hit = 1'b1;
                    r.position = POS_W'(near_at);
                end
            end
            default: ;
        endcase
        r.entry_count = COUNT_W'(held_count);
        return r;
    endfunction

    // driver: one word in flight on the port, random gaps between words
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start    <= 1'b0;
            cmd      <= '0;
            gap_left <= 0;
        end
        else if (start && !busy)
        begin
            expected_results.push_back(table_outcome(cmd));
            if ($urandom_range(0, 39) == 0)
                no_idle = !no_idle;
            gap_draw = no_idle ? 0 : $urandom_range(0, MAX_GAP);
            if (gap_draw == 0 && cmd_backlog.size() != 0)
                cmd <= cmd_backlog.pop_front();
            else
            begin
                start    <= 1'b0;
                gap_left <= (gap_draw == 0) ? 0 : gap_draw - 1;
            end
        end
        else if (!start)
        begin
            if (gap_left != 0)
                gap_left <= gap_left - 1;
            else if (cmd_backlog.size() != 0)
            begin
                cmd   <= cmd_backlog.pop_front();
                start <= 1'b1;
            end
        end
    end

    // monitor
    always @(posedge clk)
    begin
        if (rst_n && done)
        begin
            if (expected_results.size() == 0)
            begin
                fail_count++;
                if (fail_count <= REPORT_LIMIT)
                    $display("unexpected result word: %p", result);
            end
            else
            begin
                want = expected_results.pop_front();
                if (result.status !== want.status || result.exact_hit !== want.exact_hit
                    || result.near_hit !== want.near_hit
                    || result.position !== want.position
                    || result.entry_count !== want.entry_count)
                begin
                    fail_count++;
                    if (fail_count <= REPORT_LIMIT)
                    begin
                        $display("mismatch: expected status=%0d exact=%0d near=%0d pos=%0d count=%0d",
                                 want.status, want.exact_hit, want.near_hit, want.position,
                                 want.entry_count);
                        $display("          got      status=%0d exact=%0d near=%0d pos=%0d count=%0d",
                                 result.status, result.exact_hit, result.near_hit,
                                 result.position, result.entry_count);
                    end
                end
            end
        end
    end

    // watchdog
    always @(posedge clk)
    begin
        if (!rst_n || (start && !busy) || done)
            stall_cycles <= 0;
        else
        begin
            stall_cycles <= stall_cycles + 1;
            if (stall_cycles >= STALL_LIMIT)
            begin
                $display("RESULT: ERROR");
                $finish;
            end
        end
    end

    function automatic logic [KEY_W-1:0] any_word();
        return {$urandom, $urandom};
    endfunction

    function automatic logic [23:0] numbered_chars();
        logic [23:0] t;
        int d;
        for (int i = 0; i < 3; i++)
        begin
            d = $urandom_range(0, 10);
            t[i*8 +: 8] = (d == 10) ? 8'h20 : 8'(8'h30 + d);
        end
        return t;
    endfunction

    task automatic queue_cmd(input logic [1:0] op, input logic [KEY_W-1:0] kw);
        kwtab_in_t c;
        c.operation = op;
        c.keyword   = kw;
        cmd_backlog.push_back(c);
        planned_total++;
        if (op == OP_CLEAR)
            planned_words.delete();
        else if (op == OP_APPEND && planned_words.size() < TABLE_DEPTH)
            planned_words.push_back(kw);
    endtask

    task automatic plan_append();
        int pick;
        logic [KEY_W-1:0] w;
        pick = $urandom_range(0, 9);
        w = any_word();
        if (pick < 6)
            w = {stems[$urandom_range(0, 3)], numbered_chars()};
        else if (pick < 8)
            w[KEY_W-1 -: PREFIX_W] = stems[$urandom_range(0, 3)];
        queue_cmd(OP_APPEND, w);
    endtask

    task automatic plan_lookup();
        int pick;
        logic [KEY_W-1:0] k;
        pick = $urandom_range(0, 19);
        k = any_word();
        if (planned_words.size() != 0 && pick < 7)
            k = planned_words[$urandom_range(0, planned_words.size() - 1)];
        else if (planned_words.size() != 0 && pick < 14)
        begin
            k[KEY_W-1 -: PREFIX_W] =
                planned_words[$urandom_range(0, planned_words.size() - 1)][KEY_W-1 -: PREFIX_W];
            if (pick < 10)
                k[23:0] = numbered_chars();
        end
        else if (pick < 17)
            k[KEY_W-1 -: PREFIX_W] = stems[$urandom_range(0, 3)];
        queue_cmd(OP_LOOKUP, k);
    endtask

    initial
    begin
        int episode;
        int fill_to;

        stems[0] = "NAXIS";
        stems[1] = "CRVAL";
        stems[2] = PREFIX_W'(any_word());
        stems[3] = PREFIX_W'(any_word());

        // directed
        queue_cmd(OP_LOOKUP, "ABCDE123");
        queue_cmd(OP_UNUSED, '1);
        queue_cmd(OP_APPEND, "ABCDE123");
        queue_cmd(OP_APPEND, "ABCDE 9 ");
        queue_cmd(OP_APPEND, "ABCDEFGH");
        queue_cmd(OP_APPEND, '0);
        queue_cmd(OP_APPEND, '1);
        queue_cmd(OP_APPEND, "ABCDE/:0");
        queue_cmd(OP_APPEND, {"ABCDE", 8'h21, "00"});
        queue_cmd(OP_APPEND, {"ABCDE", 8'h1F, "00"});
        queue_cmd(OP_LOOKUP, "ABCDE000");
        queue_cmd(OP_LOOKUP, "ABCDE123");
        queue_cmd(OP_LOOKUP, '0);
        queue_cmd(OP_LOOKUP, '1);
        queue_cmd(OP_APPEND, "ABCDE123");
        queue_cmd(OP_LOOKUP, "ABCDE123");
        queue_cmd(OP_LOOKUP, "ABCDEzzz");
        queue_cmd(OP_LOOKUP, "ABCDF123");
        queue_cmd(OP_LOOKUP, {"ABCDE", 24'h0});
        queue_cmd(OP_UNUSED, '0);
        queue_cmd(OP_CLEAR, '1);
        queue_cmd(OP_LOOKUP, "ABCDE123");
        queue_cmd(OP_APPEND, "        ");
        queue_cmd(OP_LOOKUP, "     000");
        queue_cmd(OP_CLEAR, '0);

        // random episodes: fill, probe, sometimes overflow
        episode = 0;
        while (planned_total < 25 + RANDOM_ITEMS)
        begin
            episode++;
            if ($urandom_range(0, 4) != 0)
                queue_cmd(OP_CLEAR, any_word());
            fill_to = (episode % 6 == 1) ? TABLE_DEPTH : $urandom_range(1, 12);
            while (planned_words.size() < fill_to)
            begin
                plan_append();
                if ($urandom_range(0, 3) == 0)
                    plan_lookup();
                if ($urandom_range(0, 19) == 0)
                    queue_cmd(OP_UNUSED, any_word());
            end
            if (planned_words.size() == TABLE_DEPTH)
                repeat ($urandom_range(1, 3)) plan_append();
            repeat ($urandom_range(4, 10)) plan_lookup();
        end

        repeat (11) @(posedge clk);
        rst_n <= 1'b1;

        while (cmd_backlog.size() != 0 || start || expected_results.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (fail_count == 0 && expected_results.size() == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule

// ----- filelist.f -----
sv/kwtab_pkg.sv
sv/keyword_table_exact_near_search.sv
verif/keyword_table_exact_near_search_tb.sv
